// ===== hdl/ir_median_distance_filter_unit_assert.svh =====
// Assertion macros shared by the checker files of the distance filter.
// No dependencies; include by bare file name.
`ifndef IR_MEDIAN_DISTANCE_FILTER_UNIT_ASSERT_SVH
`define IR_MEDIAN_DISTANCE_FILTER_UNIT_ASSERT_SVH

// Clocked check, masked while reset is asserted.
`define IRMDF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked check that also runs during reset.
`define IRMDF_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== hdl/irmdf_pkg.sv =====
// Shared constants, types and register codes of the distance filter.
// No dependencies.
package irmdf_pkg;

    localparam int CHANNELS     = 4;
    localparam int CH_W         = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SAMPLE_W     = 12;
    localparam int NUM_W        = 20;
    localparam int FAR_W        = 10;
    localparam int CHAN_FIELD_W = 2;
    localparam int DIST_W       = 20;
    localparam int CNT_W        = $clog2(NUM_W);
    localparam int S_TDATA_W    = 16;
    localparam int M_TDATA_W    = 24;
    localparam int M_TUSER_W    = 8;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 20;

    localparam logic [SAMPLE_W-1:0] NEAR_THRESHOLD_RST  = 12'd494;
    localparam logic [NUM_W-1:0]    SCALE_NUMERATOR_RST = 20'd268130;
    localparam logic [SAMPLE_W-1:0] SAMPLE_OFFSET_RST   = 12'd159;
    localparam logic [FAR_W-1:0]    FAR_DISTANCE_RST    = 10'd799;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NEAR_THRESHOLD  = 2'd0,
        CFG_SCALE_NUMERATOR = 2'd1,
        CFG_SAMPLE_OFFSET   = 2'd2,
        CFG_FAR_DISTANCE    = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0]     median;
        logic [CHAN_FIELD_W-1:0] channel;
    } hist_out_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== hdl/ir_median_distance_filter_unit.sv =====
// Distance filter top level: one result word per sample word, one word at a time.
// Each sample passes the median history, a range check and, for in-range medians, the
// bit-serial divider; out-of-range medians take the far distance. A new word is taken
// only after the previous result has been loaded into the output register.
// Reset (aresetn low, synchronous) clears history, pointer and control and reloads config defaults.
// Depends on irmdf_pkg, irmdf_history, irmdf_divider.
module ir_median_distance_filter_unit import irmdf_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [11:0] adc_sample
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [19:0] distance_mm
    output logic [M_TUSER_W-1:0]  m_tuser    // [1:0] channel
);

    state_t state_reg, state_next;

    logic [SAMPLE_W-1:0] near_threshold_reg;
    logic [NUM_W-1:0]    scale_numerator_reg;
    logic [SAMPLE_W-1:0] sample_offset_reg;
    logic [FAR_W-1:0]    far_distance_reg;

    logic [DIST_W-1:0]       result_reg, result_next;
    logic                    m_valid_reg, m_valid_next;
    logic [DIST_W-1:0]       m_dist_reg;
    logic [CHAN_FIELD_W-1:0] m_chan_reg;

    logic                s_accept;
    logic                div_start;
    logic                out_load;
    logic                far_hit;
    logic [SAMPLE_W-1:0] divisor;
    hist_out_t           hist_out;
    div_stat_t           div_stat;
    logic [NUM_W-1:0]    quotient;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            near_threshold_reg  <= NEAR_THRESHOLD_RST;
            scale_numerator_reg <= SCALE_NUMERATOR_RST;
            sample_offset_reg   <= SAMPLE_OFFSET_RST;
            far_distance_reg    <= FAR_DISTANCE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_NEAR_THRESHOLD:  near_threshold_reg  <= cfg_wdata[SAMPLE_W-1:0];
                CFG_SCALE_NUMERATOR: scale_numerator_reg <= cfg_wdata[NUM_W-1:0];
                CFG_SAMPLE_OFFSET:   sample_offset_reg   <= cfg_wdata[SAMPLE_W-1:0];
                CFG_FAR_DISTANCE:    far_distance_reg    <= cfg_wdata[FAR_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    irmdf_history u_history (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (s_accept),
        .sample   (s_tdata[SAMPLE_W-1:0]),
        .hist_out (hist_out)
    );

    // medians at or below the offset also go far, so the divisor is never zero
    assign far_hit = (hist_out.median < near_threshold_reg) ||
                     (hist_out.median <= sample_offset_reg);
    assign divisor = hist_out.median - sample_offset_reg;

    irmdf_divider u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .numerator (scale_numerator_reg),
        .divisor   (divisor),
        .stat      (div_stat),
        .quotient  (quotient)
    );

    always_comb begin
        state_next   = state_reg;
        result_next  = result_reg;
        div_start    = 1'b0;
        out_load     = 1'b0;
        m_valid_next = m_valid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (far_hit) begin
                    result_next = DIST_W'(far_distance_reg);
                    state_next  = ST_DONE;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    result_next = quotient;
                    state_next  = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_tready) begin
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        result_reg <= result_next;
        if (out_load) begin
            m_dist_reg <= result_reg;
            m_chan_reg <= hist_out.channel;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(m_dist_reg);
    assign m_tuser  = M_TUSER_W'(m_chan_reg);

endmodule

// ===== hdl/irmdf_history.sv =====
// Per-channel three-sample history, round-robin channel pointer and median.
// Depends on irmdf_pkg.
module irmdf_history import irmdf_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                wr_en,
    input  logic [SAMPLE_W-1:0] sample,
    output hist_out_t           hist_out
);

    logic [SAMPLE_W-1:0]     newest_reg [CHANNELS];
    logic [SAMPLE_W-1:0]     middle_reg [CHANNELS];
    logic [CH_W-1:0]         ptr_reg;
    logic [CH_W-1:0]         ptr_next;
    logic [SAMPLE_W-1:0]     median_reg;
    logic [SAMPLE_W-1:0]     median_next;
    logic [CHAN_FIELD_W-1:0] channel_reg;

    logic [SAMPLE_W-1:0] a, b, c, lo, hi;

    // after the shift: newest = sample, middle = old newest, oldest = old middle
    always_comb begin
        a  = sample;
        b  = newest_reg[ptr_reg];
        c  = middle_reg[ptr_reg];
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (c <= lo) begin
            median_next = lo;
        end else if (c >= hi) begin
            median_next = hi;
        end else begin
            median_next = c;
        end
        ptr_next = (ptr_reg == CH_W'(CHANNELS - 1)) ? '0 : ptr_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                newest_reg[i] <= '0;
                middle_reg[i] <= '0;
            end
        end else if (wr_en) begin
            newest_reg[ptr_reg] <= sample;
            middle_reg[ptr_reg] <= newest_reg[ptr_reg];
            ptr_reg             <= ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            median_reg  <= median_next;
            channel_reg <= CHAN_FIELD_W'(ptr_reg);
        end
    end

    assign hist_out.median  = median_reg;
    assign hist_out.channel = channel_reg;

endmodule

// ===== hdl/irmdf_divider.sv =====
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
// Depends on irmdf_pkg.
module irmdf_divider import irmdf_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [NUM_W-1:0]    numerator,
    input  logic [SAMPLE_W-1:0] divisor,
    output div_stat_t           stat,
    output logic [NUM_W-1:0]    quotient
);

    logic [NUM_W-1:0]    quo_reg, quo_next;
    logic [SAMPLE_W-1:0] rem_reg, rem_next;
    logic [SAMPLE_W-1:0] div_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                busy_reg;
    logic                done_reg;

    logic [SAMPLE_W:0] trial;
    logic              ge;

    // remainder stays below the divisor, so it fits the sample width
    always_comb begin
        trial    = {rem_reg, quo_reg[NUM_W-1]};
        ge       = trial >= {1'b0, div_reg};
        rem_next = ge ? SAMPLE_W'(trial - {1'b0, div_reg}) : trial[SAMPLE_W-1:0];
        quo_next = {quo_reg[NUM_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= numerator;
            rem_reg <= '0;
            div_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

// ===== hdl/irmdf_checker.sv =====
// Port-level checks of the distance filter, bound to the top level.
// Depends on irmdf_pkg and ir_median_distance_filter_unit_assert.svh.
`include "ir_median_distance_filter_unit_assert.svh"

module irmdf_checker import irmdf_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_TDATA_W-1:0]  m_tdata,
    input logic [M_TUSER_W-1:0]  m_tuser
);

    `IRMDF_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid, "result word dropped while stalled")
    `IRMDF_ASSERT(a_out_stable, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser), "stalled result word changed")
    `IRMDF_ASSERT(a_busy_after_in, s_tvalid && s_tready |=> !s_tready, "input taken again while a word is in work")
    `IRMDF_ASSERT(a_out_from_busy, $rose(m_tvalid) |-> !$past(s_tready), "result word appeared without a word in work")
    `IRMDF_ASSERT_RST(a_reset_clear, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind ir_median_distance_filter_unit irmdf_checker u_irmdf_checker (.*);

// ===== sim/tb_ir_median_distance_filter_unit.sv =====
// Self-checking testbench for ir_median_distance_filter_unit: a median-of-three and
// reciprocal distance predictor runs beside the block and checks every result word.
// Depends on irmdf_pkg and the RTL of the filter unit.
module tb_ir_median_distance_filter_unit;
    import irmdf_pkg::*;

    localparam int DRAIN_CYCLES = 30;       // longer than the divider path
    localparam int CYCLE_LIMIT  = 600000;

    typedef struct {
        logic [CHAN_FIELD_W-1:0] chan;
        logic [DIST_W-1:0]       mm;
    } distance_word_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    cfg_idx_t              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;

    // predictor state: per-channel sample history, pointer and register copies
    logic [SAMPLE_W-1:0] hist_newest [CHANNELS];
    logic [SAMPLE_W-1:0] hist_middle [CHANNELS];
    logic [SAMPLE_W-1:0] hist_oldest [CHANNELS];
    logic [CH_W-1:0]     chan_ptr;
    logic [SAMPLE_W-1:0] cur_near;
    logic [NUM_W-1:0]    cur_num;
    logic [SAMPLE_W-1:0] cur_offset;
    logic [FAR_W-1:0]    cur_far;

    distance_word_t pending_distances[$];
    int error_count = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    ir_median_distance_filter_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        if (error_count < 100)
            $display("MISMATCH: %s", msg);
        error_count++;
    endtask

    function automatic logic [SAMPLE_W-1:0] median_of_three(input logic [SAMPLE_W-1:0] a,
                                                            input logic [SAMPLE_W-1:0] b,
                                                            input logic [SAMPLE_W-1:0] c);
        logic [SAMPLE_W-1:0] lo;
        logic [SAMPLE_W-1:0] hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (c <= lo)
            return lo;
        if (c >= hi)
            return hi;
        return c;
    endfunction

    task automatic clear_predictor();
        for (int i = 0; i < CHANNELS; i++) begin
            hist_newest[i] = '0;
            hist_middle[i] = '0;
            hist_oldest[i] = '0;
        end
        chan_ptr   = '0;
        cur_near   = NEAR_THRESHOLD_RST;
        cur_num    = SCALE_NUMERATOR_RST;
        cur_offset = SAMPLE_OFFSET_RST;
        cur_far    = FAR_DISTANCE_RST;
    endtask

    task automatic predict_distance(input logic [SAMPLE_W-1:0] smp);
        distance_word_t      w;
        logic [SAMPLE_W-1:0] med;
        hist_oldest[chan_ptr] = hist_middle[chan_ptr];
        hist_middle[chan_ptr] = hist_newest[chan_ptr];
        hist_newest[chan_ptr] = smp;
        med = median_of_three(hist_newest[chan_ptr], hist_middle[chan_ptr],
                              hist_oldest[chan_ptr]);
        w.chan = chan_ptr[CHAN_FIELD_W-1:0];
        // below threshold, or not above offset (no divide by zero / negative)
        if (med < cur_near || med <= cur_offset)
            w.mm = DIST_W'(cur_far);
        else
            w.mm = cur_num / (med - cur_offset);
        pending_distances.push_back(w);
        chan_ptr = (chan_ptr == CH_W'(CHANNELS - 1)) ? '0 : chan_ptr + 1'b1;
    endtask

    // receiver: random stall and result check
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            check_distance_word();
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    task automatic check_distance_word();
        distance_word_t want;
        if (pending_distances.size() == 0) begin
            report_mismatch($sformatf("unexpected word: channel %0d distance %0d",
                                      m_tuser[CHAN_FIELD_W-1:0], m_tdata[DIST_W-1:0]));
            return;
        end
        want = pending_distances.pop_front();
        if (m_tuser[CHAN_FIELD_W-1:0] !== want.chan)
            report_mismatch($sformatf("channel: got %0d want %0d",
                                      m_tuser[CHAN_FIELD_W-1:0], want.chan));
        if (m_tdata[DIST_W-1:0] !== want.mm)
            report_mismatch($sformatf("distance on channel %0d: got %0d want %0d",
                                      want.chan, m_tdata[DIST_W-1:0], want.mm));
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_NEAR_THRESHOLD:  cur_near   = val[SAMPLE_W-1:0];
            CFG_SCALE_NUMERATOR: cur_num    = val[NUM_W-1:0];
            CFG_SAMPLE_OFFSET:   cur_offset = val[SAMPLE_W-1:0];
            CFG_FAR_DISTANCE:    cur_far    = val[FAR_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // valid stays up across back-to-back words; within this task it is lowered only for a gap
    task automatic send_sample(input logic [SAMPLE_W-1:0] smp);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(smp);
        do
            @(posedge aclk);
        while (!s_tready);
        predict_distance(smp);
    endtask

    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        while (pending_distances.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [SAMPLE_W-1:0] clamp_sample(input int v);
        if (v < 0)
            return '0;
        if (v > 4095)
            return 12'hFFF;
        return SAMPLE_W'(v);
    endfunction

    // most samples uniform, the rest clustered around threshold and offset
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 60)
            return SAMPLE_W'($urandom_range(0, 4095));
        if (sel < 80)
            return clamp_sample(int'(cur_near) + $urandom_range(0, 16) - 8);
        return clamp_sample(int'(cur_offset) + $urandom_range(0, 16) - 8);
    endfunction

    task automatic test_default_conversion();
        logic [SAMPLE_W-1:0] seq[12] = '{12'd4095, 12'd0, 12'd494, 12'd4095,
                                         12'd4095, 12'd4095, 12'd494, 12'd493,
                                         12'd4095, 12'd0, 12'd493, 12'd160};
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        foreach (seq[i])
            send_sample(seq[i]);
        wait_all_results();
    endtask

    task automatic test_register_extremes();
        // offset at top: no median is above it
        write_reg(CFG_NEAR_THRESHOLD, 20'd0);
        write_reg(CFG_SAMPLE_OFFSET, 20'd4095);
        write_reg(CFG_SCALE_NUMERATOR, 20'hFFFFF);
        write_reg(CFG_FAR_DISTANCE, 20'd1023);
        repeat (3) send_sample(12'd4095);
        wait_all_results();
        // zero threshold and offset: zero median is far, others divide directly
        write_reg(CFG_SAMPLE_OFFSET, 20'd0);
        write_reg(CFG_FAR_DISTANCE, 20'd0);
        send_sample(12'd0);
        send_sample(12'd1);
        send_sample(12'd4095);
        send_sample(12'd1);
        wait_all_results();
        // zero numerator gives zero quotient
        write_reg(CFG_SCALE_NUMERATOR, 20'd0);
        send_sample(12'd2048);
        send_sample(12'd4095);
        wait_all_results();
        // upper data bits are dropped: threshold 4095, far 5, numerator 1
        write_reg(CFG_NEAR_THRESHOLD, 20'hFFFFF);
        write_reg(CFG_FAR_DISTANCE, 20'hFFC05);
        write_reg(CFG_SCALE_NUMERATOR, 20'd1);
        send_sample(12'd4095);
        send_sample(12'd4094);
        send_sample(12'd4095);
        wait_all_results();
        write_reg(CFG_NEAR_THRESHOLD, 20'd1);
        write_reg(CFG_SAMPLE_OFFSET, 20'hFF000);
        send_sample(12'd4095);
        send_sample(12'd4095);
        wait_all_results();
    endtask

    task automatic load_random_config(input bit use_defaults);
        logic [SAMPLE_W-1:0] near_v;
        logic [NUM_W-1:0]    num_v;
        logic [SAMPLE_W-1:0] off_v;
        logic [FAR_W-1:0]    far_v;
        if (use_defaults) begin
            near_v = NEAR_THRESHOLD_RST;
            num_v  = SCALE_NUMERATOR_RST;
            off_v  = SAMPLE_OFFSET_RST;
            far_v  = FAR_DISTANCE_RST;
        end else begin
            near_v = SAMPLE_W'($urandom_range(0, 1500));
            num_v  = ($urandom_range(0, 3) == 0) ? NUM_W'($urandom_range(0, 4000))
                                                 : NUM_W'($urandom);
            off_v  = SAMPLE_W'($urandom_range(0, 800));
            far_v  = FAR_W'($urandom);
        end
        write_reg(CFG_NEAR_THRESHOLD, {8'($urandom), near_v});
        write_reg(CFG_SCALE_NUMERATOR, num_v);
        write_reg(CFG_SAMPLE_OFFSET, {8'($urandom), off_v});
        write_reg(CFG_FAR_DISTANCE, {10'($urandom), far_v});
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                     input int count, input bit use_defaults);
        load_random_config(use_defaults);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++) begin
            // one stretch without idling in each phase
            if (i == count / 2)
                send_idle_pct = 0;
            if (i == count / 2 + 30)
                send_idle_pct = idle_pct;
            // sender holds off until the block has emptied
            if (i == count / 4)
                wait_all_results();
            send_sample(pick_sample());
        end
        wait_all_results();
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_NEAR_THRESHOLD;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        clear_predictor();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        test_default_conversion();
        test_register_extremes();
        test_random_phase(0, 0, 175, 1'b1);
        test_random_phase(46, 0, 175, 1'b0);
        test_random_phase(0, 46, 175, 1'b0);
        test_random_phase(23, 23, 175, 1'b0);

        if (pending_distances.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_distances.size()));
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
